[sv/lstf_pkg.sv]
// Shared types and constants of the light status frame tracker.
package lstf_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_STATUS_ACK  = 2'd0;
    localparam logic [1:0] CFG_CONTROL_ACK = 2'd1;
    localparam logic [1:0] CFG_POLLED      = 2'd2;

    // Stored power state codes of one light.
    localparam logic [1:0] PS_UNKNOWN = 2'd0;
    localparam logic [1:0] PS_OFF     = 2'd1;
    localparam logic [1:0] PS_ON      = 2'd2;

    // Depth of the request queue between the front and the back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Power command carried by a frame.
    typedef enum logic [1:0] {
        PWR_NONE,
        PWR_SET_OFF,
        PWR_SET_ON
    } lstf_pwr_cmd_t;

    // Kind of a result.
    typedef enum logic [1:0] {
        KIND_POWER  = 2'd0,
        KIND_DIM    = 2'd1,
        KIND_STATUS = 2'd2
    } lstf_kind_t;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_POWER,
        ST_DIM,
        ST_SCAN,
        ST_STATUS
    } lstf_state_t;

    // A classified frame as it travels through the queue.
    typedef struct packed {
        logic          accept;
        lstf_pwr_cmd_t pwr_cmd;
        logic          dimm;
        logic [7:0]    num;
        logic [7:0]    lvl;
        logic [7:0]    mx;
    } lstf_req_t;

    // Queue status seen by both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } lstf_qstat_t;

    // Per-light record held in the back end memory.
    typedef struct packed {
        logic [1:0] power_state;
        logic [7:0] dim_level;
        logic [7:0] max_level;
    } lstf_rec_t;

    // One result.
    typedef struct packed {
        lstf_kind_t kind;
        logic [4:0] light;
        logic       dimm;
        logic       pon;
        logic [7:0] level;
        logic [4:0] lead;
        logic       link;
        logic       ign;
        logic       last;
    } lstf_res_t;

endpackage

[sv/lstf_front.sv]
// Front end: takes frame requests and classifies them for the back end.
module lstf_front #(
    parameter int LIGHTS = 16
) (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tuser,   // frame_type
    input  logic [31:0]         s_tdata,   // power_byte, light_number, level_byte, max_level_byte
    input  logic [7:0]          status_ack_code,
    input  logic [7:0]          control_ack_code,
    input  lstf_pkg::lstf_qstat_t qstat,
    output logic                push,
    output lstf_pkg::lstf_req_t push_data
);
    import lstf_pkg::*;

    logic [7:0] power_byte;
    logic [7:0] light_number;
    logic       type_ok;
    logic       num_ok;

    assign power_byte   = s_tdata[7:0];
    assign light_number = s_tdata[15:8];

    // A request is taken whenever the queue has room.
    assign s_tready = !qstat.full;
    assign push     = s_tvalid && !qstat.full;

    // A frame counts only if it is an acknowledgement for a light in range.
    assign type_ok = (s_tuser == status_ack_code) || (s_tuser == control_ack_code);
    assign num_ok  = (light_number != 8'd0) && (light_number <= 8'(LIGHTS));

    always_comb begin
        push_data.accept = type_ok && num_ok;
        push_data.dimm   = (s_tdata[31:24] != 8'd0);
        push_data.num    = light_number;
        push_data.lvl    = s_tdata[23:16];
        push_data.mx     = s_tdata[31:24];
        case (power_byte)
            8'd0:    push_data.pwr_cmd = PWR_SET_OFF;
            8'd1:    push_data.pwr_cmd = PWR_SET_ON;
            default: push_data.pwr_cmd = PWR_NONE;
        endcase
    end

endmodule

[sv/lstf_queue.sv]
// Short request queue that decouples the front end from the back end.
module lstf_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  lstf_pkg::lstf_req_t   push_data,
    input  logic                  pop,
    output lstf_pkg::lstf_req_t   pop_data,
    output lstf_pkg::lstf_qstat_t qstat
);
    import lstf_pkg::*;

    lstf_req_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;

    assign qstat.full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign pop_data    = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/lstf_back.sv]
// Back end: per-light state, event generation and the leading acknowledgement count.
module lstf_back #(
    parameter int LIGHTS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lstf_pkg::lstf_req_t   q_data,
    input  lstf_pkg::lstf_qstat_t qstat,
    output logic                  q_pop,
    input  logic [4:0]            polled_count,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lstf_pkg::lstf_res_t   out_res
);
    import lstf_pkg::*;

    localparam int IDX_W  = (LIGHTS > 1) ? $clog2(LIGHTS) : 1;
    localparam int LEAD_W = $clog2(LIGHTS + 1);
    localparam int CMP_W  = (LEAD_W > 5) ? LEAD_W : 5;

    lstf_state_t       state_reg, state_next;
    lstf_req_t         cur_reg;
    lstf_rec_t         rec_mem [LIGHTS];
    lstf_rec_t         rd_rec_reg;
    logic              rd_valid_reg;
    logic [LIGHTS-1:0] valid_reg;
    logic [LIGHTS-1:0] acked_reg;
    logic [LEAD_W-1:0] lead_reg;
    logic              pwr_ev_reg;
    logic              pon_reg;
    logic              dim_ev_reg;
    lstf_res_t         out_reg, res_next;
    logic              out_valid_reg;

    logic [7:0]        num_m1;
    logic [IDX_W-1:0]  idx;
    logic              out_free;
    logic              scan_done;
    logic              exec_en;
    logic              load_pwr;
    logic              load_dim;
    logic              load_stat;
    logic              scan_step;

    lstf_rec_t         rec_old;
    lstf_rec_t         rec_new;
    logic              pwr_ev;
    logic              pon;
    logic              dim_ev;

    logic [CMP_W-1:0]  lead_ext;
    logic [CMP_W-1:0]  limit_ext;
    logic [CMP_W-1:0]  lead_min;

    assign num_m1    = cur_reg.num - 8'd1;
    assign idx       = num_m1[IDX_W-1:0];
    assign out_free  = !out_valid_reg || out_ready;
    assign scan_done = (lead_reg == LEAD_W'(LIGHTS)) || !acked_reg[lead_reg[IDX_W-1:0]];
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!qstat.empty) begin
                    state_next = q_data.accept ? ST_FETCH : ST_STATUS;
                end
            end
            ST_FETCH: state_next = ST_EXEC;
            ST_EXEC:  state_next = ST_POWER;
            ST_POWER: begin
                if (!pwr_ev_reg || out_free) begin
                    state_next = ST_DIM;
                end
            end
            ST_DIM: begin
                if (!dim_ev_reg || out_free) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_STATUS;
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        q_pop     = 1'b0;
        exec_en   = 1'b0;
        load_pwr  = 1'b0;
        load_dim  = 1'b0;
        load_stat = 1'b0;
        scan_step = 1'b0;
        case (state_reg)
            ST_IDLE:   q_pop     = !qstat.empty;
            ST_EXEC:   exec_en   = 1'b1;
            ST_POWER:  load_pwr  = pwr_ev_reg && out_free;
            ST_DIM:    load_dim  = dim_ev_reg && out_free;
            ST_SCAN:   scan_step = !scan_done;
            ST_STATUS: load_stat = out_free;
            default: begin
            end
        endcase
    end

    // Update of one light's record from the frame; entries never written read as reset.
    always_comb begin
        if (rd_valid_reg) begin
            rec_old = rd_rec_reg;
        end else begin
            rec_old.power_state = PS_UNKNOWN;
            rec_old.dim_level   = 8'hFF;
            rec_old.max_level   = 8'd0;
        end
        rec_new = rec_old;
        pwr_ev  = 1'b0;
        pon     = 1'b0;
        dim_ev  = 1'b0;
        case (cur_reg.pwr_cmd)
            PWR_SET_OFF: begin
                if (rec_old.power_state != PS_OFF) begin
                    rec_new.power_state = PS_OFF;
                    rec_new.dim_level   = 8'd0;
                    pwr_ev              = 1'b1;
                end
            end
            PWR_SET_ON: begin
                if (rec_old.power_state != PS_ON) begin
                    rec_new.power_state = PS_ON;
                    rec_new.dim_level   = rec_old.max_level;
                    pwr_ev              = 1'b1;
                    pon                 = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (!cur_reg.dimm) begin
            rec_new.dim_level = 8'd0;
            rec_new.max_level = 8'd0;
        end else begin
            dim_ev            = (rec_new.dim_level != cur_reg.lvl);
            rec_new.dim_level = cur_reg.lvl;
            rec_new.max_level = cur_reg.mx;
        end
    end

    // Status count: leading acknowledged lights, limited by the polled count.
    always_comb begin
        lead_ext  = CMP_W'(lead_reg);
        limit_ext = CMP_W'(polled_count);
        if (limit_ext > CMP_W'(LIGHTS)) begin
            limit_ext = CMP_W'(LIGHTS);
        end
        lead_min = (lead_ext < limit_ext) ? lead_ext : limit_ext;
    end

    // Result to load into the output register.
    always_comb begin
        res_next = '0;
        if (load_pwr) begin
            res_next.kind  = KIND_POWER;
            res_next.light = cur_reg.num[4:0];
            res_next.dimm  = cur_reg.dimm;
            res_next.pon   = pon_reg;
            res_next.level = (pon_reg && cur_reg.dimm) ? cur_reg.lvl : 8'd0;
        end else if (load_dim) begin
            res_next.kind  = KIND_DIM;
            res_next.light = cur_reg.num[4:0];
            res_next.dimm  = 1'b1;
            res_next.level = cur_reg.lvl;
        end else begin
            res_next.kind  = KIND_STATUS;
            res_next.light = cur_reg.accept ? cur_reg.num[4:0] : 5'd0;
            res_next.lead  = lead_min[4:0];
            res_next.link  = (lead_min != '0);
            res_next.ign   = !cur_reg.accept;
            res_next.last  = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            acked_reg     <= '0;
            lead_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (exec_en) begin
                valid_reg[idx] <= 1'b1;
                acked_reg[idx] <= 1'b1;
            end
            if (scan_step) begin
                lead_reg <= lead_reg + 1'b1;
            end
            if (load_pwr || load_dim || load_stat) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_data;
        end
        if (exec_en) begin
            pwr_ev_reg <= pwr_ev;
            pon_reg    <= pon;
            dim_ev_reg <= dim_ev;
        end
        if (load_pwr || load_dim || load_stat) begin
            out_reg <= res_next;
        end
    end

    // Per-light record memory with a registered read.
    always_ff @(posedge aclk) begin
        rd_rec_reg   <= rec_mem[idx];
        rd_valid_reg <= valid_reg[idx];
        if (exec_en) begin
            rec_mem[idx] <= rec_new;
        end
    end

endmodule

[sv/light_status_frame_tracker.sv]
// A taken frame waits in the queue until the idle back end sequencer pops it. An ignored frame
// goes straight to the status state; an accepted one passes through the fetch, exec, power, dim,
// scan and status states, scan stepping once for each light that newly joins the leading
// acknowledged run, and any result waits while the result side holds off. The back end handles
// one frame at a time; a two-entry queue lets the front keep taking frames. Reset (synchronous,
// active low) clears the configuration and control registers, the queue pointers, the sequencer,
// the acknowledged and per-light valid bits; record memory entries read as reset values until written.
module light_status_frame_tracker #(
    parameter int LIGHTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tuser,   // frame_type
    input  logic [31:0] s_tdata,   // power_byte, light_number, level_byte, max_level_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // event_kind
    output logic [23:0] m_tdata,   // event_light, is_dimmable, power_on, event_level,
                                   // leading_acked, link_up, frame_ignored, zero pad
    output logic        m_tlast,   // last
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);
    import lstf_pkg::*;

    logic [7:0]  status_ack_reg;
    logic [7:0]  control_ack_reg;
    logic [4:0]  polled_reg;

    lstf_qstat_t qstat;
    logic        push;
    lstf_req_t   push_data;
    logic        pop;
    lstf_req_t   pop_data;
    lstf_res_t   res;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_ack_reg  <= '0;
            control_ack_reg <= '0;
            polled_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_STATUS_ACK:  status_ack_reg  <= cfg_wdata;
                CFG_CONTROL_ACK: control_ack_reg <= cfg_wdata;
                CFG_POLLED:      polled_reg      <= cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

    lstf_front #(
        .LIGHTS (LIGHTS)
    ) u_front (
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tuser          (s_tuser),
        .s_tdata          (s_tdata),
        .status_ack_code  (status_ack_reg),
        .control_ack_code (control_ack_reg),
        .qstat            (qstat),
        .push             (push),
        .push_data        (push_data)
    );

    lstf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    lstf_back #(
        .LIGHTS (LIGHTS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_data       (pop_data),
        .qstat        (qstat),
        .q_pop        (pop),
        .polled_count (polled_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_res      (res)
    );

    // Result packing.
    assign m_tuser = res.kind;
    assign m_tlast = res.last;
    assign m_tdata = {2'b00, res.ign, res.link, res.lead, res.level, res.pon, res.dimm, res.light};

    // The status result, and only it, closes a frame.
    a_last_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == KIND_STATUS)))
        else $error("last flag does not match the status result");

    // Link-up follows the leading count in a status result.
    a_link_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_STATUS) |-> (m_tdata[20] == (m_tdata[19:15] != 5'd0)))
        else $error("link-up disagrees with the leading count");

    // An ignored frame reports no light.
    a_ignored_no_light: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_STATUS && m_tdata[21]) |-> (m_tdata[4:0] == 5'd0))
        else $error("ignored frame reports a light number");

    // The back end never pops an empty queue, and a full queue refuses requests.
    a_queue_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && qstat.empty) && !(qstat.full && s_tready))
        else $error("queue handshake inconsistent");

endmodule
